@@ rtl/tbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tbfs_pkg: shared types and constants of the two-bank flash store
// Request codes, configuration register indexes, controller states and the
// memory control word that the controller hands to the bank memories.
// ----------------------------------------------------------------------------
package tbfs_pkg;

  localparam int unsigned CODE_BYTES_DEF      = 65536;
  localparam int unsigned DATA_BYTES_DEF      = 4096;
  localparam int unsigned CODE_PAGE_BYTES_DEF = 512;
  localparam int unsigned DATA_PAGE_BYTES_DEF = 512;

  // Value of an erased flash byte.
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  // Low address bits dropped when a start address is aligned to a word.
  localparam logic [31:0] ALIGN_MASK  = 32'h0000_0003;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 2'd1;

  typedef enum logic [1:0] {
    REQ_READ = 2'd0,
    REQ_PROG = 2'd1,
    REQ_PAGE = 2'd2,
    REQ_CHIP = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REL,
    ST_LOC,
    ST_MEM,
    ST_RESP,
    ST_ERASE
  } fsm_state_t;

  typedef struct packed {
    logic code_en;
    logic data_en;
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

@@ rtl/tbfs_bank.sv @@
// ----------------------------------------------------------------------------
// tbfs_bank: byte-wide flash bank memory
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module tbfs_bank #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/tbfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbfs_ctrl: request sequencer of the two-bank flash store
// Holds the base registers, computes bank locations, runs the clearing pass
// and the erase sweeps, and does the read-modify-write of a program.
// ----------------------------------------------------------------------------
module tbfs_ctrl
  import tbfs_pkg::*;
#(
  parameter int unsigned CODE_BYTES      = CODE_BYTES_DEF,
  parameter int unsigned DATA_BYTES      = DATA_BYTES_DEF,
  parameter int unsigned CODE_PAGE_BYTES = CODE_PAGE_BYTES_DEF,
  parameter int unsigned DATA_PAGE_BYTES = DATA_PAGE_BYTES_DEF,
  parameter int unsigned MAX_BYTES = (CODE_BYTES > DATA_BYTES) ? CODE_BYTES : DATA_BYTES,
  parameter int unsigned ADDR_W    = $clog2(MAX_BYTES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic                 bank,
  input  logic [31:0]          start_address,
  input  logic [15:0]          byte_offset,
  input  logic [7:0]           write_byte,
  output logic [7:0]           read_byte,
  output logic                 in_range,
  output logic                 done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output mem_ctl_t             mem_ctl,
  output logic [ADDR_W-1:0]    mem_addr,
  output logic [7:0]           mem_wdata,
  input  logic [7:0]           code_rdata,
  input  logic [7:0]           data_rdata
);

  localparam int unsigned CNT_W = ADDR_W + 1;
  localparam logic [32:0] CODE_SIZE = 33'(CODE_BYTES);
  localparam logic [32:0] DATA_SIZE = 33'(DATA_BYTES);
  localparam logic [32:0] CODE_PAGE = 33'(CODE_PAGE_BYTES);
  localparam logic [32:0] DATA_PAGE = 33'(DATA_PAGE_BYTES);
  localparam logic [CNT_W-1:0] CODE_CNT = CNT_W'(CODE_BYTES);
  localparam logic [CNT_W-1:0] DATA_CNT = CNT_W'(DATA_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BYTES);

  fsm_state_t state, state_next;
  req_t       req, req_next;
  logic       bank_r, bank_r_next;
  logic [31:0] addr_r, addr_r_next;
  logic [15:0] offs_r, offs_r_next;
  logic [7:0]  wbyte_r, wbyte_r_next;
  logic [31:0] rel, rel_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] cnt_end, cnt_end_next;
  logic        ok, ok_next;
  logic [31:0] code_base, data_base;
  logic        done_next;
  logic [7:0]  read_byte_next;
  logic        in_range_next;

  logic [31:0] base_sel;
  logic [31:0] aligned;
  logic [32:0] diff;
  logic [32:0] size_sel;
  logic [32:0] page_sel;
  logic [32:0] loc_sum;
  logic [32:0] page_sum;
  logic [7:0]  rdata_sel;
  logic [CNT_W-1:0] cnt_inc;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign mem_addr  = cnt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      code_base <= '0;
      data_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CODE_BASE: code_base <= cfg_data;
        CFG_DATA_BASE: data_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    bank_r    <= bank_r_next;
    addr_r    <= addr_r_next;
    offs_r    <= offs_r_next;
    wbyte_r   <= wbyte_r_next;
    rel       <= rel_next;
    cnt_end   <= cnt_end_next;
    ok        <= ok_next;
    read_byte <= read_byte_next;
    in_range  <= in_range_next;
  end

  always_comb begin
    base_sel  = bank_r ? data_base : code_base;
    aligned   = addr_r & ~ALIGN_MASK;
    diff      = {1'b0, aligned} - {1'b0, base_sel};
    size_sel  = bank_r ? DATA_SIZE : CODE_SIZE;
    page_sel  = bank_r ? DATA_PAGE : CODE_PAGE;
    loc_sum   = {1'b0, rel} + 33'(offs_r);
    page_sum  = {1'b0, rel} + page_sel;
    rdata_sel = bank_r ? data_rdata : code_rdata;
    cnt_inc   = cnt + 1'b1;

    state_next     = state;
    req_next       = req;
    bank_r_next    = bank_r;
    addr_r_next    = addr_r;
    offs_r_next    = offs_r;
    wbyte_r_next   = wbyte_r;
    rel_next       = rel;
    cnt_next       = cnt;
    cnt_end_next   = cnt_end;
    ok_next        = ok;
    done_next      = 1'b0;
    read_byte_next = read_byte;
    in_range_next  = in_range;
    mem_ctl        = '0;
    mem_wdata      = ERASED_BYTE;

    unique case (state)
      ST_CLEAR: begin
        // Both banks are swept together; the smaller one drops out early.
        mem_ctl.code_en = (cnt < CODE_CNT);
        mem_ctl.data_en = (cnt < DATA_CNT);
        mem_ctl.wr      = 1'b1;
        cnt_next        = cnt_inc;
        if (cnt_inc == MAX_CNT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_next     = req_t'(req_type);
          bank_r_next  = bank;
          addr_r_next  = start_address;
          offs_r_next  = byte_offset;
          wbyte_r_next = write_byte;
          state_next   = ST_REL;
        end
      end
      ST_REL: begin
        if (req == REQ_CHIP) begin
          cnt_next     = '0;
          cnt_end_next = size_sel[CNT_W-1:0];
          ok_next      = 1'b1;
          state_next   = ST_ERASE;
        end else begin
          // An aligned start below the base is raised to the base.
          rel_next   = diff[32] ? '0 : diff[31:0];
          state_next = ST_LOC;
        end
      end
      ST_LOC: begin
        if (req == REQ_PAGE) begin
          ok_next      = ({1'b0, rel} < size_sel);
          cnt_next     = rel[CNT_W-1:0];
          cnt_end_next = (page_sum > size_sel) ? size_sel[CNT_W-1:0]
                                               : page_sum[CNT_W-1:0];
          state_next   = ok_next ? ST_ERASE : ST_RESP;
        end else begin
          ok_next    = (loc_sum < size_sel);
          cnt_next   = loc_sum[CNT_W-1:0];
          state_next = ST_MEM;
        end
      end
      ST_MEM: begin
        mem_ctl.code_en = ok && !bank_r;
        mem_ctl.data_en = ok && bank_r;
        mem_ctl.rd      = 1'b1;
        state_next      = ST_RESP;
      end
      ST_RESP: begin
        if (req == REQ_PROG && ok) begin
          mem_ctl.code_en = !bank_r;
          mem_ctl.data_en = bank_r;
          mem_ctl.wr      = 1'b1;
          mem_wdata       = rdata_sel & wbyte_r;
        end
        done_next      = 1'b1;
        read_byte_next = (req == REQ_READ && ok) ? rdata_sel : 8'h00;
        in_range_next  = ok;
        state_next     = ST_IDLE;
      end
      ST_ERASE: begin
        mem_ctl.code_en = !bank_r;
        mem_ctl.data_en = bank_r;
        mem_ctl.wr      = 1'b1;
        cnt_next        = cnt_inc;
        if (cnt_inc == cnt_end) begin
          state_next = ST_RESP;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.rd && mem_ctl.wr))
    else $error("memory read and write issued together");

  a_both_banks_clear: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.code_en && mem_ctl.data_en) |-> (state == ST_CLEAR))
    else $error("both banks enabled outside the clearing pass");

  a_read_needs_range: assert property (@(posedge clk) disable iff (rst)
    (done && (read_byte != 8'h00)) |-> in_range)
    else $error("nonzero read data on an out-of-range result");

  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_RESP))
    else $error("result strobe without a response cycle");

endmodule

@@ rtl/two_bank_flash_store_unit.sv @@
// ----------------------------------------------------------------------------
// two_bank_flash_store_unit: code and data flash banks with page erase
// Top level: request sequencer plus one synchronous memory per bank.
// ----------------------------------------------------------------------------
// Usage. A request word is taken at a clock edge where start is high and
// busy is low. Each request yields exactly one result word: done is high
// for one cycle and read_byte and in_range are valid in that same cycle.
// The receiver cannot stall, so the result must be captured when done is
// high. For reads and programs, the request passes the relocation,
// location, memory and response states in order, and done is registered
// in the response state. Busy drops in the cycle that shows done, so a new
// word may be accepted at the edge that ends it. A program is a
// read-modify-write of the addressed byte through the single memory port.
// A page erase writes one byte per cycle over the page, clipped at the end
// of the bank. After reset both banks are swept to 0xFF, one byte per
// cycle, with busy high. The base registers are written on the config
// channel, which is always ready; writes to indexes beyond the data base
// are ignored.
// ----------------------------------------------------------------------------
module two_bank_flash_store_unit
  import tbfs_pkg::*;
#(
  parameter int unsigned CODE_BYTES      = CODE_BYTES_DEF,
  parameter int unsigned DATA_BYTES      = DATA_BYTES_DEF,
  parameter int unsigned CODE_PAGE_BYTES = CODE_PAGE_BYTES_DEF,
  parameter int unsigned DATA_PAGE_BYTES = DATA_PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic                 bank,
  input  logic [31:0]          start_address,
  input  logic [15:0]          byte_offset,
  input  logic [7:0]           write_byte,
  output logic                 done,
  output logic [7:0]           read_byte,
  output logic                 in_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned MAX_BYTES = (CODE_BYTES > DATA_BYTES) ? CODE_BYTES : DATA_BYTES;
  localparam int unsigned ADDR_W    = $clog2(MAX_BYTES);
  localparam int unsigned CODE_AW   = $clog2(CODE_BYTES);
  localparam int unsigned DATA_AW   = $clog2(DATA_BYTES);

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        code_rdata;
  logic [7:0]        data_rdata;

  tbfs_ctrl #(
    .CODE_BYTES      (CODE_BYTES),
    .DATA_BYTES      (DATA_BYTES),
    .CODE_PAGE_BYTES (CODE_PAGE_BYTES),
    .DATA_PAGE_BYTES (DATA_PAGE_BYTES),
    .MAX_BYTES       (MAX_BYTES),
    .ADDR_W          (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .bank          (bank),
    .start_address (start_address),
    .byte_offset   (byte_offset),
    .write_byte    (write_byte),
    .read_byte     (read_byte),
    .in_range      (in_range),
    .done          (done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mem_ctl       (mem_ctl),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .code_rdata    (code_rdata),
    .data_rdata    (data_rdata)
  );

  // Each bank sees only the low address bits that its depth needs.
  tbfs_bank #(
    .DEPTH (CODE_BYTES),
    .AW    (CODE_AW)
  ) u_code_bank (
    .clk   (clk),
    .en    (mem_ctl.code_en && (mem_ctl.rd || mem_ctl.wr)),
    .we    (mem_ctl.wr),
    .addr  (mem_addr[CODE_AW-1:0]),
    .wdata (mem_wdata),
    .rdata (code_rdata)
  );

  tbfs_bank #(
    .DEPTH (DATA_BYTES),
    .AW    (DATA_AW)
  ) u_data_bank (
    .clk   (clk),
    .en    (mem_ctl.data_en && (mem_ctl.rd || mem_ctl.wr)),
    .we    (mem_ctl.wr),
    .addr  (mem_addr[DATA_AW-1:0]),
    .wdata (mem_wdata),
    .rdata (data_rdata)
  );

endmodule

@@ tb/flash_store_checker.sv @@
// ----------------------------------------------------------------------------
// flash_store_checker: result checker for the two-bank flash store
// Keeps its own copy of both flash banks and of the base registers, works
// out the result word of every accepted request and compares it with the
// result words that the block returns, oldest first.
// ----------------------------------------------------------------------------
module flash_store_checker
  import tbfs_pkg::*;
#(
  parameter int unsigned CODE_BYTES      = CODE_BYTES_DEF,
  parameter int unsigned DATA_BYTES      = DATA_BYTES_DEF,
  parameter int unsigned CODE_PAGE_BYTES = CODE_PAGE_BYTES_DEF,
  parameter int unsigned DATA_PAGE_BYTES = DATA_PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           req_type,
  input  logic                 bank,
  input  logic [31:0]          start_address,
  input  logic [15:0]          byte_offset,
  input  logic [7:0]           write_byte,
  input  logic                 done,
  input  logic [7:0]           read_byte,
  input  logic                 in_range,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [7:0] byte_val;
    logic       hit;
  } flash_result_t;

  logic [7:0]    code_flash [CODE_BYTES];
  logic [7:0]    data_flash [DATA_BYTES];
  logic [31:0]   code_base_q;
  logic [31:0]   data_base_q;
  flash_result_t expected_q [$];
  flash_result_t want;

  // Carries out one request on the model banks and returns its result word.
  function automatic flash_result_t apply_request(req_t kind, logic sel,
                                                  logic [31:0] addr,
                                                  logic [15:0] offs,
                                                  logic [7:0] wdata);
    logic [31:0]   base;
    logic [31:0]   aligned;
    logic [31:0]   rel;
    logic [32:0]   loc;
    int unsigned   size;
    int unsigned   page;
    int unsigned   last;
    flash_result_t res;
    res.byte_val = '0;
    res.hit      = 1'b0;
    base    = sel ? data_base_q : code_base_q;
    size    = sel ? DATA_BYTES : CODE_BYTES;
    page    = sel ? DATA_PAGE_BYTES : CODE_PAGE_BYTES;
    aligned = addr & ~ALIGN_MASK;
    if (aligned < base) aligned = base;
    rel = aligned - base;
    case (kind)
      REQ_CHIP: begin
        for (int unsigned i = 0; i < size; i++) begin
          if (sel) data_flash[i] = ERASED_BYTE;
          else     code_flash[i] = ERASED_BYTE;
        end
        res.hit = 1'b1;
      end
      REQ_PAGE: begin
        if (rel < size) begin
          last = (rel + page > size) ? size : rel + page;
          for (int unsigned i = rel; i < last; i++) begin
            if (sel) data_flash[i] = ERASED_BYTE;
            else     code_flash[i] = ERASED_BYTE;
          end
          res.hit = 1'b1;
        end
      end
      default: begin
        loc = {1'b0, rel} + 33'(offs);
        if (loc < 33'(size)) begin
          if (kind == REQ_READ) begin
            res.byte_val = sel ? data_flash[loc] : code_flash[loc];
          end else if (sel) begin
            data_flash[loc] = data_flash[loc] & wdata;
          end else begin
            code_flash[loc] = code_flash[loc] & wdata;
          end
          res.hit = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int unsigned i = 0; i < CODE_BYTES; i++) code_flash[i] = ERASED_BYTE;
      for (int unsigned i = 0; i < DATA_BYTES; i++) data_flash[i] = ERASED_BYTE;
      code_base_q = '0;
      data_base_q = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      // A result word leaves before a new request is taken in the same
      // cycle; it always belongs to an earlier request.
      if (done === 1'b1) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("result word with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          if (read_byte !== want.byte_val) begin
            mismatches++;
            $error("read_byte: expected %02h, actual %02h", want.byte_val, read_byte);
          end
          if (in_range !== want.hit) begin
            mismatches++;
            $error("in_range: expected %0b, actual %0b", want.hit, in_range);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CODE_BASE: code_base_q = cfg_data;
          CFG_DATA_BASE: data_base_q = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_q.push_back(apply_request(req_t'(req_type), bank, start_address,
                                           byte_offset, write_byte));
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: top level for the two-bank flash store unit
// Drives request words and base register writes into the block and leaves
// all prediction and comparison to the checker that sits beside it. A short
// directed part comes first, then three random phases with different bank
// bases and different amounts of idle time on the request side.
// ----------------------------------------------------------------------------
module testbench;
  import tbfs_pkg::*;

  localparam int unsigned CODE_SIZE = CODE_BYTES_DEF;
  localparam int unsigned DATA_SIZE = DATA_BYTES_DEF;

  // Worst case stays far below this: one reset sweep of the code bank, at
  // most a handful of code chip erases, a few dozen page erases and about
  // four hundred short requests with idle gaps.
  localparam int unsigned LIMIT_CYCLES = 5_000_000;

  // Index that names no register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           req_type;
  logic                 bank;
  logic [31:0]          start_address;
  logic [15:0]          byte_offset;
  logic [7:0]           write_byte;
  logic                 done;
  logic [7:0]           read_byte;
  logic                 in_range;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int          mismatches;
  int          pending;
  int unsigned cycle_count = 0;

  // Request side idle rate in percent, and the bases the block now holds,
  // so that random addresses can be aimed at the banks.
  int unsigned idle_pct;
  logic [31:0] code_base_now;
  logic [31:0] data_base_now;
  int unsigned code_chip_erases;

  two_bank_flash_store_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .bank          (bank),
    .start_address (start_address),
    .byte_offset   (byte_offset),
    .write_byte    (write_byte),
    .done          (done),
    .read_byte     (read_byte),
    .in_range      (in_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  flash_store_checker #(
    .CODE_BYTES      (CODE_SIZE),
    .DATA_BYTES      (DATA_SIZE),
    .CODE_PAGE_BYTES (CODE_PAGE_BYTES_DEF),
    .DATA_PAGE_BYTES (DATA_PAGE_BYTES_DEF)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .bank          (bank),
    .start_address (start_address),
    .byte_offset   (byte_offset),
    .write_byte    (write_byte),
    .done          (done),
    .read_byte     (read_byte),
    .in_range      (in_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog. A hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one request word. All driving happens at the falling edge with
  // blocking assignments, so each input changes at most once per step. While
  // the sender idles, start is low and the fields carry noise that the block
  // must ignore. On return we sit at the falling edge after acceptance with
  // start still high; the next call either keeps it high or lowers it.
  task automatic issue(req_t kind, logic sel, logic [31:0] addr, logic [15:0] offs,
                       logic [7:0] wdata);
    while ($urandom_range(0, 99) < idle_pct) begin
      start         = 1'b0;
      req_type      = 2'($urandom());
      bank          = 1'($urandom());
      start_address = $urandom();
      byte_offset   = 16'($urandom());
      write_byte    = 8'($urandom());
      @(negedge clk);
    end
    start         = 1'b1;
    req_type      = kind;
    bank          = sel;
    start_address = addr;
    byte_offset   = offs;
    write_byte    = wdata;
    // The word is taken at the first rising edge where busy is low.
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Holds the request side off until every result word is back and the
  // block has gone idle.
  task automatic wait_drained();
    start = 1'b0;
    while (pending != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  // One write on the register channel; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_bases(logic [31:0] code_base, logic [31:0] data_base);
    wait_drained();
    write_reg(CFG_CODE_BASE, code_base);
    write_reg(CFG_DATA_BASE, data_base);
    code_base_now = code_base;
    data_base_now = data_base;
  endtask

  // One random request. Half of the addresses land in a small window at the
  // start of the bank so that programs, reads and page erases keep meeting
  // the same bytes; the rest go near the end of the bank, anywhere in it,
  // just below the base, or anywhere at all.
  task automatic random_request();
    int unsigned pick;
    int unsigned size;
    logic        sel;
    logic [31:0] base;
    logic [31:0] addr;
    logic [15:0] offs;
    logic [7:0]  wdata;
    req_t        kind;
    sel  = 1'($urandom());
    size = sel ? DATA_SIZE : CODE_SIZE;
    base = sel ? data_base_now : code_base_now;
    pick = $urandom_range(0, 99);
    if (pick < 50)      addr = base + $urandom_range(0, 63);
    else if (pick < 70) addr = base + size - $urandom_range(1, 64);
    else if (pick < 80) addr = base + $urandom_range(0, size - 1);
    else if (pick < 88) addr = base - $urandom_range(1, 256);
    else                addr = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 60)      offs = 16'($urandom_range(0, 15));
    else if (pick < 85) offs = 16'($urandom_range(0, 1023));
    else if (pick < 95) offs = 16'($urandom());
    else                offs = 16'hFFFF;
    if ($urandom_range(0, 1) == 0) wdata = 8'($urandom());
    else                           wdata = ~(8'h01 << $urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 45)      kind = REQ_READ;
    else if (pick < 85) kind = REQ_PROG;
    else if (pick < 97) kind = REQ_PAGE;
    else                kind = REQ_CHIP;
    // A code chip erase walks the whole code bank, so only a few are allowed.
    if (kind == REQ_CHIP && sel == 1'b0) begin
      if (code_chip_erases < 3 && $urandom_range(0, 3) == 0) code_chip_erases++;
      else sel = 1'b1;
    end
    issue(kind, sel, addr, offs, wdata);
  endtask

  initial begin
    rst              = 1'b1;
    start            = 1'b0;
    req_type         = REQ_READ;
    bank             = 1'b0;
    start_address    = '0;
    byte_offset      = '0;
    write_byte       = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_CODE_BASE;
    cfg_data         = '0;
    idle_pct         = 0;
    code_base_now    = '0;
    data_base_now    = '0;
    code_chip_erases = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Bases at zero. The reset sweep keeps busy high for a while, which
    // set_bases waits out before its register writes.
    set_bases(32'h0000_0000, 32'h0000_0000);

    // Directed words: erased reads, AND behavior of programs, misaligned
    // starts, the last byte of each bank reached by address and by offset,
    // one byte past the end, page erases whole, clipped and past the end,
    // and chip erases with junk in the ignored fields.
    issue(REQ_READ, 1'b0, 32'h0000_0000, 16'h0000, 8'h00);
    issue(REQ_PROG, 1'b0, 32'h0000_0003, 16'h0001, 8'h00);
    issue(REQ_PROG, 1'b0, 32'h0000_0000, 16'h0002, 8'hA5);
    issue(REQ_PROG, 1'b0, 32'h0000_0002, 16'h0002, 8'h3C);
    issue(REQ_READ, 1'b0, 32'h0000_0001, 16'h0001, 8'hFF);
    issue(REQ_READ, 1'b0, 32'h0000_0000, 16'h0002, 8'h5A);
    issue(REQ_PROG, 1'b0, 32'h0000_0000, 16'hFFFF, 8'h0F);
    issue(REQ_READ, 1'b0, 32'h0000_FFFC, 16'h0003, 8'h00);
    issue(REQ_READ, 1'b0, 32'h0000_FFFC, 16'h0004, 8'h00);
    issue(REQ_PROG, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
    issue(REQ_PROG, 1'b1, 32'h0000_0FFF, 16'h0003, 8'h81);
    issue(REQ_READ, 1'b1, 32'h0000_0FFC, 16'h0003, 8'h00);
    issue(REQ_READ, 1'b1, 32'h0000_1000, 16'h0000, 8'h00);
    issue(REQ_PAGE, 1'b0, 32'h0000_0001, 16'hFFFF, 8'h00);
    issue(REQ_READ, 1'b0, 32'h0000_0000, 16'h0002, 8'h00);
    issue(REQ_PAGE, 1'b0, 32'h0000_FF00, 16'h0000, 8'h00);
    issue(REQ_READ, 1'b0, 32'h0000_FFFC, 16'h0003, 8'h00);
    issue(REQ_PAGE, 1'b0, 32'h0001_0000, 16'h0000, 8'h00);
    issue(REQ_PAGE, 1'b1, 32'h0000_0F80, 16'h0000, 8'h00);
    issue(REQ_PROG, 1'b1, 32'h0000_0000, 16'h0000, 8'h00);
    issue(REQ_CHIP, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    issue(REQ_READ, 1'b1, 32'h0000_0000, 16'h0000, 8'h00);
    issue(REQ_CHIP, 1'b0, 32'h1234_5678, 16'h0000, 8'h00);

    // First random phase: no idling on the request side. Halfway through,
    // the sender stops until every result word has come back.
    idle_pct = 0;
    for (int i = 0; i < 130; i++) begin
      if (i == 65) wait_drained();
      random_request();
    end

    // Second phase: bases at the top of the address space. Every code start
    // lies below the code base and is raised to it, and a write to an
    // index that names no register must leave both bases alone.
    set_bases(32'hFFFF_FFFF, 32'hFFFF_F000);
    write_reg(CFG_NO_REG, 32'h5A5A_A5A5);
    issue(REQ_PROG, 1'b0, 32'h0000_0000, 16'h0005, 8'h7E);
    issue(REQ_READ, 1'b0, 32'hFFFF_FFFF, 16'h0005, 8'h00);
    issue(REQ_READ, 1'b1, 32'hFFFF_FFFC, 16'h0003, 8'h00);
    issue(REQ_READ, 1'b1, 32'hFFFF_FFFC, 16'h0004, 8'h00);
    idle_pct = 81;
    for (int i = 0; i < 130; i++) random_request();

    // Third phase: random bases, moderate idling.
    set_bases($urandom(), $urandom());
    idle_pct = 29;
    for (int i = 0; i < 140; i++) random_request();

    // Drain, then give the block a few more cycles to show any stray word.
    wait_drained();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tbfs_pkg.sv
rtl/tbfs_bank.sv
rtl/tbfs_ctrl.sv
rtl/two_bank_flash_store_unit.sv
tb/flash_store_checker.sv
tb/testbench.sv
